/* src/rpf_pkg.sv */
`timescale 1ns / 1ps
package rpf_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_START  = 2'd0;
  localparam logic [1:0] CFG_END    = 2'd1;
  localparam logic [1:0] CFG_ESCAPE = 2'd2;

  localparam logic [7:0] START_RESET  = 8'h24;
  localparam logic [7:0] END_RESET    = 8'h23;
  localparam logic [7:0] ESCAPE_RESET = 8'h7d;
  localparam logic [7:0] FLIP_MASK    = 8'h20;

  // ascii bases for lowercase hex digits
  localparam logic [7:0] DIGIT_BASE  = 8'h30;
  localparam logic [7:0] LETTER_BASE = 8'h57;

  // command queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_packet;
  } pkt_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_done;
  } ser_beat_t;

  // one classified item, ready to be sent
  typedef struct packed {
    logic       esc;
    logic [7:0] esc_byte;
    logic [7:0] data;
    logic       eop;
    logic [7:0] end_byte;
    logic [7:0] chk;
  } q_entry_t;

  typedef enum logic [2:0] {
    PH_NEW,
    PH_ESC,
    PH_DATA,
    PH_END,
    PH_HI,
    PH_LO
  } phase_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] n8;
    n8 = {4'd0, nib};
    return (nib < 4'd10) ? (DIGIT_BASE + n8) : (LETTER_BASE + n8);
  endfunction

endpackage

/* src/rpf_front.sv */
`timescale 1ns / 1ps
module rpf_front import rpf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       pkt_valid,
  input  pkt_item_t  pkt,
  input  logic       q_full,
  output logic       push,
  output q_entry_t   entry
);

  logic [7:0] start_char;
  logic [7:0] end_char;
  logic [7:0] escape_char;
  logic [7:0] running_sum;
  logic       awaiting_first;

  logic       match;
  logic [7:0] data_x;
  logic [7:0] sum_next;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_char  <= START_RESET;
      end_char    <= END_RESET;
      escape_char <= ESCAPE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_START:  start_char  <= cfg_data;
        CFG_END:    end_char    <= cfg_data;
        CFG_ESCAPE: escape_char <= cfg_data;
        default:    ;
      endcase
    end
  end

  assign push = pkt_valid && !q_full;

  // classify the byte and fold it into the checksum
  always_comb begin
    match  = (pkt.data_byte == escape_char) || (pkt.data_byte == start_char) ||
             (pkt.data_byte == end_char);
    data_x = pkt.data_byte ^ FLIP_MASK;
    if (awaiting_first) begin
      sum_next = 8'd0;
    end else if (match) begin
      sum_next = running_sum + escape_char + data_x;
    end else begin
      sum_next = running_sum + pkt.data_byte;
    end
    entry.esc      = !awaiting_first && match;
    entry.esc_byte = escape_char;
    entry.data     = (!awaiting_first && match) ? data_x : pkt.data_byte;
    entry.eop      = pkt.end_of_packet;
    entry.end_byte = end_char;
    entry.chk      = sum_next;
  end

  // packet tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum    <= 8'd0;
      awaiting_first <= 1'b1;
    end else if (push) begin
      running_sum    <= pkt.end_of_packet ? 8'd0 : sum_next;
      awaiting_first <= pkt.end_of_packet;
    end
  end

endmodule

/* src/rpf_queue.sv */
`timescale 1ns / 1ps
module rpf_queue import rpf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  q_entry_t push_data,
  input  logic     pop,
  output logic     full,
  output logic     head_valid,
  output q_entry_t head
);

  q_entry_t           slots [QDEPTH];
  logic [QAW-1:0]     wr_ptr;
  logic [QAW-1:0]     rd_ptr;
  logic [QCW-1:0]     count;

  assign full       = (count == QCW'(QDEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QAW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QAW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* src/rpf_back.sv */
`timescale 1ns / 1ps
module rpf_back import rpf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      head_valid,
  input  q_entry_t  head,
  output logic      pop,
  output logic      ser_valid,
  input  logic      ser_stall,
  output ser_beat_t ser
);

  phase_t    phase;
  phase_t    phase_next;
  phase_t    cur;
  logic      load;
  ser_beat_t beat;

  assign load = head_valid && (!ser_valid || !ser_stall);

  // a fresh entry starts with its escape byte or its data byte
  always_comb begin
    if (phase == PH_NEW) begin
      cur = head.esc ? PH_ESC : PH_DATA;
    end else begin
      cur = phase;
    end
  end

  // next phase
  always_comb begin
    phase_next = phase;
    if (load) begin
      case (cur)
        PH_ESC:  phase_next = PH_DATA;
        PH_DATA: phase_next = head.eop ? PH_END : PH_NEW;
        PH_END:  phase_next = PH_HI;
        PH_HI:   phase_next = PH_LO;
        PH_LO:   phase_next = PH_NEW;
        default: phase_next = PH_NEW;
      endcase
    end
  end

  // beat contents and queue pop
  always_comb begin
    beat.run_last   = 1'b0;
    beat.frame_done = 1'b0;
    case (cur)
      PH_ESC:  beat.out_byte = head.esc_byte;
      PH_DATA: begin
        beat.out_byte = head.data;
        beat.run_last = !head.eop;
      end
      PH_END:  beat.out_byte = head.end_byte;
      PH_HI:   beat.out_byte = hex_digit(head.chk[7:4]);
      PH_LO:   begin
        beat.out_byte   = hex_digit(head.chk[3:0]);
        beat.run_last   = 1'b1;
        beat.frame_done = 1'b1;
      end
      default: beat.out_byte = head.data;
    endcase
    pop = load && beat.run_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_NEW;
      ser_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      if (load) begin
        ser_valid <= 1'b1;
      end else if (!ser_stall) begin
        ser_valid <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (load) begin
      ser <= beat;
    end
  end

endmodule

/* src/rsp_packet_framer_core.sv */
`timescale 1ns / 1ps
// Packet framer for a debug remote serial link, sending side.
// Input channel pkt_valid / pkt_stall / pkt: one packet byte per beat with an
// end-of-packet mark. The first byte of a packet goes out unchanged; later
// bytes that equal the start, end or escape character go out as the escape
// character and the byte xor 0x20. After the last byte come the end
// character and the checksum as two lowercase hex digits.
// Output channel ser_valid / ser_stall / ser: one wire byte per beat, with
// run_last on the final beat of each input byte and frame_done on the
// second checksum digit.
// Configuration: cfg_valid / cfg_ready with cfg_index (0 start, 1 end,
// 2 escape) and cfg_data; index 3 is ignored. cfg_ready is always high.
// Write only while no packet byte is still being sent.
// The first beat of an input byte passes through the command queue and the
// output register before it is valid. Each input byte causes 1 to 5 wire
// beats, so throughput is set by the single output register: one wire byte
// per cycle while ser_stall is low. A four-entry command queue lets input
// keep flowing while a result waits.
// Reset clears the queue and ser_valid, restores the default characters and
// starts a new packet. While ser_stall is high the output beat holds; once
// the queue fills, pkt_stall rises.
module rsp_packet_framer_core import rpf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       pkt_valid,
  output logic       pkt_stall,
  input  pkt_item_t  pkt,
  output logic       ser_valid,
  input  logic       ser_stall,
  output ser_beat_t  ser
);

  logic     q_full;
  logic     push;
  logic     pop;
  logic     head_valid;
  q_entry_t entry;
  q_entry_t head;

  assign cfg_ready = 1'b1;
  assign pkt_stall = q_full;

  rpf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pkt_valid (pkt_valid),
    .pkt       (pkt),
    .q_full    (q_full),
    .push      (push),
    .entry     (entry)
  );

  rpf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (entry),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  rpf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .ser_valid  (ser_valid),
    .ser_stall  (ser_stall),
    .ser        (ser)
  );

endmodule
